FILE: sv/byte_memory_sized_access_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte memory sized access unit
// Shared forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef BYTE_MEMORY_SIZED_ACCESS_UNIT_ASSERT_SVH
`define BYTE_MEMORY_SIZED_ACCESS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/bmsa_pkg.sv
// ----------------------------------------------------------------------------
// bmsa_pkg
// Types and codes shared by the byte memory sized access unit.
// ----------------------------------------------------------------------------
package bmsa_pkg;

	localparam int MEM_BYTES_DEF = 1024;
	localparam int MEM_SIZE_W = 11;
	localparam logic [MEM_SIZE_W-1:0] MEM_SIZE_RST = 11'd1024;
	localparam int ADDR_W = 16;
	localparam int DATA_W = 32;
	localparam int LANES = 4;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;
	localparam logic [1:0] SZ_BAD = 2'd3;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic has_result;
		logic is_read;
		logic bad;
		logic [LANES-1:0] byte_en;
		logic [LANES-1:0][7:0] byte_data;
	} bmsa_acc_t;

	// Number of bytes an access covers; zero for the undefined code.
	function automatic logic [2:0] size_bytes(input logic [1:0] code);
		logic [2:0] n;
		unique case (code)
			SZ_BYTE: n = 3'd1;
			SZ_HALF: n = 3'd2;
			SZ_WORD: n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

FILE: sv/bmsa_req_if.sv
// ----------------------------------------------------------------------------
// bmsa_req_if
// Request channel: access kind, size, address and write value.
// ----------------------------------------------------------------------------
interface bmsa_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic [1:0] access_size;
	logic [15:0] address;
	logic [31:0] write_value;

	modport source (output valid, kind, access_size, address, write_value, input ready);
	modport sink (input valid, kind, access_size, address, write_value, output ready);
endinterface

FILE: sv/bmsa_rsp_if.sv
// ----------------------------------------------------------------------------
// bmsa_rsp_if
// Response channel: assembled read value and violation flag.
// ----------------------------------------------------------------------------
interface bmsa_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] read_value;
	logic violation;

	modport source (output valid, read_value, violation, input ready);
	modport sink (input valid, read_value, violation, output ready);
endinterface

FILE: sv/bmsa_bank.sv
// ----------------------------------------------------------------------------
// bmsa_bank
// One byte-wide synchronous single-port bank with registered read data.
// ----------------------------------------------------------------------------
module bmsa_bank #(
	parameter int DEPTH = 256,
	parameter int ROW_W = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [ROW_W-1:0] row,
	input  logic [7:0]       wdata,
	output logic [7:0]       rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[row] <= wdata;
			end else begin
				rdata <= mem[row];
			end
		end
	end

endmodule

FILE: sv/bmsa_decode.sv
// ----------------------------------------------------------------------------
// bmsa_decode
// Range check and lane steering of one request onto the four byte banks.
// ----------------------------------------------------------------------------
module bmsa_decode
	import bmsa_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF,
	parameter int ROW_W = 8
) (
	input  logic                  kind,
	input  logic [1:0]            access_size,
	input  logic [15:0]           address,
	input  logic [31:0]           write_value,
	input  logic [MEM_SIZE_W-1:0] mem_size,
	output bmsa_acc_t             acc,
	output logic [ROW_W-1:0]      rows [LANES]
);

	localparam logic [16:0] MEM_LIM = 17'(MEM_BYTES);

	logic [16:0] lim;
	logic [16:0] mem_ext;
	logic [16:0] addr_ext;
	logic [2:0] nbytes;
	logic [31:0] wv;
	logic [ROW_W-1:0] base;
	logic [1:0] k;

	always_comb begin
		mem_ext = 17'(mem_size);
		lim = (mem_ext < MEM_LIM) ? mem_ext : MEM_LIM;
		addr_ext = {1'b0, address};
		nbytes = size_bytes(access_size);
		base = address[ROW_W+1:2];

		acc.is_read = (kind == KIND_READ);
		acc.bad = (access_size == SZ_BAD) || ((addr_ext + 17'(nbytes)) > lim);
		acc.has_result = acc.is_read || acc.bad;

		case (access_size)
			SZ_BYTE: wv = {24'd0, (|write_value[31:8]) ? 8'hff : write_value[7:0]};
			SZ_HALF: wv = {16'd0, write_value[15:0]};
			default: wv = write_value;
		endcase

		k = 2'd0;
		for (int b = 0; b < LANES; b++) begin
			// Bank b carries byte k of the access; lanes below the start wrap to the next row.
			k = 2'(b) - address[1:0];
			acc.byte_en[b] = (kind == KIND_WRITE) && ({1'b0, k} < nbytes)
				&& ((addr_ext + 17'(k)) < lim);
			acc.byte_data[b] = wv[8*k +: 8];
			rows[b] = base + ROW_W'(2'(b) < address[1:0]);
		end
	end

endmodule

FILE: sv/byte_memory_sized_access_unit.sv
// ----------------------------------------------------------------------------
// byte_memory_sized_access_unit
// Byte-addressed memory with little-endian sized accesses and range check.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while it is not clearing and no result
// waits untaken: the four byte banks, interleaved by the two low address bits,
// serve any aligned or unaligned access in one parallel bank access, and a result
// appears in the cycle after its request from the bank read registers, then waits
// in that stage until it is taken while the next request is accepted in the same
// cycle. Writes without violation give no result. After reset the unit clears
// the memory one row of four bytes a cycle and takes no request until that
// sweep ends; mem_size writes are taken at any time.
`include "byte_memory_sized_access_unit_assert.svh"

module byte_memory_sized_access_unit
	import bmsa_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [MEM_SIZE_W-1:0] cfg_wdata,
	bmsa_req_if.sink              req,
	bmsa_rsp_if.source            rsp
);

	localparam int ROWS = (MEM_BYTES + LANES - 1) / LANES;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [MEM_SIZE_W-1:0] mem_size_q;
	logic clearing_q;
	logic [ROW_W-1:0] clr_row_q;

	bmsa_acc_t acc;
	logic [ROW_W-1:0] rows [LANES];
	logic req_acc;

	logic [LANES-1:0] bank_en;
	logic [LANES-1:0] bank_we;
	logic [ROW_W-1:0] bank_row [LANES];
	logic [7:0] bank_wdata [LANES];
	logic [7:0] bank_rdata [LANES];

	logic rsp_valid_s1;
	logic is_read_s1;
	logic bad_s1;
	logic [1:0] size_s1;
	logic [1:0] lo_s1;

	logic [2:0] nbytes_s1;
	logic [31:0] assembled;

	bmsa_decode #(
		.MEM_BYTES(MEM_BYTES),
		.ROW_W(ROW_W)
	) u_decode (
		.kind(req.kind),
		.access_size(req.access_size),
		.address(req.address),
		.write_value(req.write_value),
		.mem_size(mem_size_q),
		.acc(acc),
		.rows(rows)
	);

	assign req.ready = !clearing_q && (!rsp_valid_s1 || rsp.ready);
	assign req_acc = req.valid && req.ready;

	always_comb begin
		for (int b = 0; b < LANES; b++) begin
			bank_en[b] = clearing_q || (req_acc && (acc.is_read || acc.byte_en[b]));
			bank_we[b] = clearing_q || (req_acc && acc.byte_en[b]);
			bank_row[b] = clearing_q ? clr_row_q : rows[b];
			bank_wdata[b] = clearing_q ? 8'd0 : acc.byte_data[b];
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_bank
		bmsa_bank #(
			.DEPTH(ROWS),
			.ROW_W(ROW_W)
		) u_bank (
			.clk(clk),
			.en(bank_en[g]),
			.we(bank_we[g]),
			.row(bank_row[g]),
			.wdata(bank_wdata[g]),
			.rdata(bank_rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= MEM_SIZE_RST;
		end else if (cfg_we) begin
			mem_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q <= '0;
		end else if (clearing_q) begin
			clr_row_q <= clr_row_q + ROW_W'(1);
			if (clr_row_q == ROW_W'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s1 <= 1'b0;
		end else if (req_acc) begin
			rsp_valid_s1 <= acc.has_result;
		end else if (rsp.ready) begin
			rsp_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			is_read_s1 <= acc.is_read;
			bad_s1 <= acc.bad;
			size_s1 <= req.access_size;
			lo_s1 <= req.address[1:0];
		end
	end

	// Byte k of the result sits in the bank k lanes above the start lane, wrapping modulo four.
	always_comb begin
		nbytes_s1 = size_bytes(size_s1);
		for (int k = 0; k < LANES; k++) begin
			assembled[8*k +: 8] = ({1'b0, 2'(k)} < nbytes_s1) ?
				bank_rdata[2'(lo_s1 + 2'(k))] : 8'd0;
		end
	end

	assign rsp.valid = rsp_valid_s1;
	assign rsp.violation = bad_s1;
	assign rsp.read_value = (is_read_s1 && !bad_s1) ? assembled : 32'd0;

	`BMSA_ASSERT_SAME(a_no_req_in_clear, clk, arst_n, clearing_q, !req.ready, "request taken during clear")
	`BMSA_ASSERT_NEXT(a_clean_write_silent, clk, arst_n, req_acc && !acc.is_read && !acc.bad, !rsp.valid, "clean write gave a result")
	`BMSA_ASSERT_NEXT(a_bad_code_flags, clk, arst_n, req_acc && (req.access_size == SZ_BAD), rsp.valid && rsp.violation, "undefined size not flagged")
	`BMSA_ASSERT_SAME(a_violation_zero, clk, arst_n, rsp.valid && rsp.violation, rsp.read_value == 32'd0, "violation with nonzero value")

endmodule
